FILE: rtl/rcs_pkg.sv
package rcs_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned NAME_CHARS_DEF = 8;

  // Widths fixed by the record format
  localparam int unsigned MODE_W = 3;
  localparam int unsigned KEY_W  = 128;

  // Sort mode codes
  localparam logic [MODE_W-1:0] MODE_NAME_SURNAME = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SURNAME_NAME = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BIRTH_DATE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NUMBER       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COURSE       = 3'd4;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_LOC,
    ST_OUT
  } state_e;

  // One person record as held in a cell
  typedef struct packed {
    logic [63:0] first_name;
    logic [63:0] surname;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [30:0] number;
    logic [23:0] course;
  } rec_t;

  // Per-cell load controls
  typedef struct packed {
    logic load_new;
    logic load_prev;
    logic load_next;
  } cell_ctl_t;

  // A name cut at its first zero byte, top aligned and zero padded
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  len;
  } name_cut_t;

  function automatic name_cut_t cut_name(logic [63:0] v, int unsigned nchars);
    name_cut_t  r;
    logic       alive;
    logic [7:0] b;
    r.bytes = '0;
    r.len   = '0;
    alive   = 1'b1;
    for (int i = 0; i < 8; i++) begin
      b = v[63-8*i -: 8];
      if (alive && (i < nchars) && (b != 8'h00)) begin
        r.bytes[63-8*i -: 8] = b;
        r.len = r.len + 4'd1;
      end else begin
        alive = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [23:0] cut_course(logic [23:0] v);
    logic [23:0] r;
    logic        alive;
    logic [7:0]  b;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < 3; i++) begin
      b = v[23-8*i -: 8];
      if (alive && (b != 8'h00)) begin
        r[23-8*i -: 8] = b;
      end else begin
        alive = 1'b0;
      end
    end
    return r;
  endfunction

  // Sort key as one unsigned word: a smaller key means an earlier record.
  // Cut strings hold no zero bytes, so zero padding gives the prefix rule.
  // Year, month and day sit side by side in their own bit fields, so the date
  // value orders exactly as year, month, day.
  function automatic logic [KEY_W-1:0] make_key(logic [MODE_W-1:0] mode, rec_t rec,
                                                int unsigned nchars);
    logic [KEY_W-1:0] k;
    name_cut_t        a;
    name_cut_t        b;
    a = '0;
    b = '0;
    case (mode)
      MODE_NAME_SURNAME: begin
        a = cut_name(rec.first_name, nchars);
        b = cut_name(rec.surname, nchars);
        k = {a.bytes, 64'h0} | ({b.bytes, 64'h0} >> {a.len, 3'b000});
      end
      MODE_SURNAME_NAME: begin
        a = cut_name(rec.surname, nchars);
        b = cut_name(rec.first_name, nchars);
        k = {a.bytes, 64'h0} | ({b.bytes, 64'h0} >> {a.len, 3'b000});
      end
      MODE_BIRTH_DATE: k = {105'h0, rec.year, rec.month, rec.day};
      MODE_NUMBER:     k = {97'h0, rec.number};
      MODE_COURSE:     k = {104'h0, cut_course(rec.course)};
      // Undefined modes: equal keys, so arrival order is kept
      default:         k = '0;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/rcs_cell.sv
module rcs_cell #(
  parameter int unsigned NAME_CHARS = rcs_pkg::NAME_CHARS_DEF
) (
  input  logic                       clk_i,
  input  logic [rcs_pkg::MODE_W-1:0] mode_i,
  input  logic                       valid_i,
  input  logic [rcs_pkg::KEY_W-1:0]  new_key_i,
  input  rcs_pkg::rec_t              new_rec_i,
  input  rcs_pkg::rec_t              prev_rec_i,
  input  rcs_pkg::rec_t              next_rec_i,
  input  rcs_pkg::cell_ctl_t         ctl_i,
  output rcs_pkg::rec_t              rec_o,
  output logic                       ge_o
);

  rcs_pkg::rec_t             rec_q;
  logic [rcs_pkg::KEY_W-1:0] key;

  // Key of the held record under the current mode
  assign key = rcs_pkg::make_key(mode_i, rec_q, NAME_CHARS);

  // Held record that the new one does not precede
  assign ge_o = valid_i & ~(new_key_i < key);

  // Load from the request, the left neighbor (insert) or the right one (drain)
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_new) begin
      rec_q <= new_rec_i;
    end else if (ctl_i.load_prev) begin
      rec_q <= prev_rec_i;
    end else if (ctl_i.load_next) begin
      rec_q <= next_rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

FILE: rtl/rcs_locate.sv
module rcs_locate #(
  parameter int unsigned CAPACITY = rcs_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CAPACITY-1:0] ge_i,
  output logic [CAPACITY-1:0] after_o
);

  localparam int unsigned GROUP = 8;
  localparam int unsigned NG    = (CAPACITY + GROUP - 1) / GROUP;
  localparam int unsigned PAD   = NG * GROUP;

  logic [PAD-1:0] ge_pad;
  logic [PAD-1:0] sfx_d, sfx_q;
  logic [NG-1:0]  grp_d, grp_q;
  logic [NG-1:0]  tail;

  assign ge_pad = PAD'(ge_i);

  // Suffix OR inside each group of eight cells, plus the group OR
  always_comb begin
    logic acc;
    acc   = 1'b0;
    sfx_d = '0;
    grp_d = '0;
    for (int g = 0; g < NG; g++) begin
      acc = 1'b0;
      for (int i = GROUP - 1; i >= 0; i--) begin
        acc = acc | ge_pad[g*GROUP+i];
        sfx_d[g*GROUP+i] = acc;
      end
      grp_d[g] = acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sfx_q <= '0;
      grp_q <= '0;
    end else begin
      sfx_q <= sfx_d;
      grp_q <= grp_d;
    end
  end

  // OR of all groups to the right of each group
  always_comb begin
    logic acc;
    acc  = 1'b0;
    tail = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      tail[g] = acc;
      acc = acc | grp_q[g];
    end
  end

  // A cell lies after the insertion point when no cell from it rightward
  // holds a record the new one does not precede
  for (genvar j = 0; j < CAPACITY; j++) begin : g_after
    localparam int unsigned G = j / GROUP;
    assign after_o[j] = ~(sfx_q[j] | tail[G]);
  end

  // The after flags form one contiguous run up to the right end
  a_after_suffix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (after_o[CAPACITY-2:0] & ~after_o[CAPACITY-1:1]) == '0)
    else $error("after flags not a suffix");

endmodule

FILE: rtl/record_insertion_sorter.sv
// Stable insertion sorter for person records. Each request is a record
// that is inserted into a row of CAPACITY cells after every held record it
// does not precede under the current sort_mode (0 first name then surname,
// 1 surname then first name, 2 birth date, 3 record number, 4 course; other
// codes keep arrival order). Per record: accept, a compare in every cell at
// once, then a registered locate of the insertion point and the shift of the
// row. While a record is at work no new one is accepted. A record that finds
// the row full is dropped and sets the overflowed flag. A record with
// last_record set is followed by the drain: the row shifts one cell a cycle
// into the output register, giving one result a cycle while out_ready_i is
// high, the final one with last_out_o set, after which the row is empty. The
// output register decouples both sides, so the next record is accepted while
// the final result still waits. sort_mode must be written through cfg_we_i /
// cfg_data_i only while the block is idle; the block does not enforce it.
module record_insertion_sorter #(
  parameter int unsigned CAPACITY   = rcs_pkg::CAPACITY_DEF,
  parameter int unsigned NAME_CHARS = rcs_pkg::NAME_CHARS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rcs_pkg::MODE_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [63:0]                first_name_i,
  input  logic [63:0]                surname_i,
  input  logic [4:0]                 birth_day_i,
  input  logic [3:0]                 birth_month_i,
  input  logic [13:0]                birth_year_i,
  input  logic [30:0]                record_number_i,
  input  logic [23:0]                course_code_i,
  input  logic                       last_record_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [63:0]                out_first_name_o,
  output logic [63:0]                out_surname_o,
  output logic [4:0]                 out_day_o,
  output logic [3:0]                 out_month_o,
  output logic [13:0]                out_year_o,
  output logic [30:0]                out_number_o,
  output logic [23:0]                out_course_o,
  output logic                       overflowed_o,
  output logic                       last_out_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  rcs_pkg::state_e           state_q, state_d;
  logic [rcs_pkg::MODE_W-1:0] mode_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      dropped_q, dropped_d;
  logic                      last_q;
  rcs_pkg::rec_t             rec_q;
  rcs_pkg::rec_t             out_rec_q;
  logic                      out_ovf_q, out_last_q, out_valid_q;

  logic                      full;
  logic                      do_insert;
  logic                      out_load;
  logic [rcs_pkg::KEY_W-1:0] new_key;
  logic [CAPACITY-1:0]       ge;
  logic [CAPACITY-1:0]       after;
  rcs_pkg::rec_t             cell_rec [CAPACITY];
  rcs_pkg::cell_ctl_t        ctl      [CAPACITY];

  assign full    = (count_q == CNT_W'(CAPACITY));
  assign new_key = rcs_pkg::make_key(mode_q, rec_q, NAME_CHARS);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcs_pkg::ST_IDLE: if (in_valid_i) state_d = rcs_pkg::ST_CMP;
      rcs_pkg::ST_CMP:  state_d = rcs_pkg::ST_LOC;
      rcs_pkg::ST_LOC:  state_d = last_q ? rcs_pkg::ST_OUT : rcs_pkg::ST_IDLE;
      rcs_pkg::ST_OUT:  if (out_load && (count_q == CNT_W'(1))) state_d = rcs_pkg::ST_IDLE;
      default:          state_d = rcs_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    do_insert  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      rcs_pkg::ST_IDLE: in_ready_o = 1'b1;
      rcs_pkg::ST_CMP:  ;
      rcs_pkg::ST_LOC:  do_insert = ~full;
      rcs_pkg::ST_OUT:  out_load = ~out_valid_q | out_ready_i;
      default:          ;
    endcase
  end

  // Fill count and drop flag
  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (state_q == rcs_pkg::ST_LOC) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (out_load) begin
      count_d = count_q - CNT_W'(1);
      if (count_q == CNT_W'(1)) begin
        dropped_d = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcs_pkg::ST_IDLE;
      mode_q      <= rcs_pkg::MODE_NAME_SURNAME;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        last_q <= last_record_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rec_q.first_name <= first_name_i;
      rec_q.surname    <= surname_i;
      rec_q.year       <= birth_year_i;
      rec_q.month      <= birth_month_i;
      rec_q.day        <= birth_day_i;
      rec_q.number     <= record_number_i;
      rec_q.course     <= course_code_i;
    end
    if (out_load) begin
      out_rec_q  <= cell_rec[0];
      out_ovf_q  <= dropped_q;
      out_last_q <= (count_q == CNT_W'(1));
    end
  end

  // Row of cells
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    rcs_pkg::rec_t prev_rec;
    rcs_pkg::rec_t next_rec;
    logic          valid;

    if (j == 0) begin : g_first
      assign prev_rec        = rec_q;
      assign ctl[j].load_new  = do_insert & after[j];
      assign ctl[j].load_prev = 1'b0;
    end else begin : g_rest
      assign prev_rec        = cell_rec[j-1];
      assign ctl[j].load_new  = do_insert & after[j] & ~after[j-1];
      assign ctl[j].load_prev = do_insert & after[j] & after[j-1];
    end

    if (j == CAPACITY - 1) begin : g_last
      assign next_rec = cell_rec[j];
    end else begin : g_mid
      assign next_rec = cell_rec[j+1];
    end

    assign ctl[j].load_next = out_load;
    assign valid = (CNT_W'(j) < count_q);

    rcs_cell #(
      .NAME_CHARS(NAME_CHARS)
    ) u_cell (
      .clk_i      (clk_i),
      .mode_i     (mode_q),
      .valid_i    (valid),
      .new_key_i  (new_key),
      .new_rec_i  (rec_q),
      .prev_rec_i (prev_rec),
      .next_rec_i (next_rec),
      .ctl_i      (ctl[j]),
      .rec_o      (cell_rec[j]),
      .ge_o       (ge[j])
    );
  end

  // Insertion point from the compare flags
  rcs_locate #(
    .CAPACITY(CAPACITY)
  ) u_locate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ge_i    (ge),
    .after_o (after)
  );

  assign out_valid_o      = out_valid_q;
  assign out_first_name_o = out_rec_q.first_name;
  assign out_surname_o    = out_rec_q.surname;
  assign out_day_o        = out_rec_q.day;
  assign out_month_o      = out_rec_q.month;
  assign out_year_o       = out_rec_q.year;
  assign out_number_o     = out_rec_q.number;
  assign out_course_o     = out_rec_q.course;
  assign overflowed_o     = out_ovf_q;
  assign last_out_o       = out_last_q;

  // Fill count never passes capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // Drain only runs on a non-empty row
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcs_pkg::ST_OUT) |-> (count_q != '0))
    else $error("drain with empty row");

  // An insert grows the row by exactly one record
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the row");

  // The final result leaves the row empty with the drop flag cleared
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (count_q == CNT_W'(1))) |=>
      (count_q == '0) && !dropped_q && (state_q == rcs_pkg::ST_IDLE))
    else $error("row not emptied after final result");

endmodule

FILE: tb/record_insertion_sorter_tb.sv
`timescale 1ns / 1ps

module record_insertion_sorter_tb;

  localparam int unsigned CAPACITY      = rcs_pkg::CAPACITY_DEF;
  localparam int unsigned NAME_CHARS    = rcs_pkg::NAME_CHARS_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;       // covers the insert
  localparam int unsigned DRAIN_SLACK   = 20;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_ITEMS  = 70;
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned MAX_REPORTS   = 10;

  // Mode codes the block leaves undefined (arrival order kept)
  localparam logic [rcs_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [rcs_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  // Byte string built from one or two cut fields, top aligned
  typedef struct packed {
    logic [127:0] bytes;
    logic [4:0]   n;
  } key_text_t;

  // One sorted record as it should leave the block
  typedef struct packed {
    rcs_pkg::rec_t rec;
    logic          overflowed;
    logic          last;
  } sorted_out_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [rcs_pkg::MODE_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [63:0] first_name;
  logic [63:0] surname;
  logic [4:0] birth_day;
  logic [3:0] birth_month;
  logic [13:0] birth_year;
  logic [30:0] record_number;
  logic [23:0] course_code;
  logic last_record;
  logic out_valid;
  logic out_ready;
  logic [63:0] out_first_name;
  logic [63:0] out_surname;
  logic [4:0] out_day;
  logic [3:0] out_month;
  logic [13:0] out_year;
  logic [30:0] out_number;
  logic [23:0] out_course;
  logic overflowed;
  logic last_out;

  // Shadow of the block: held records in order, drop flag, current mode
  rcs_pkg::rec_t              roster_q[$];
  logic                       roster_dropped = 1'b0;
  logic [rcs_pkg::MODE_W-1:0] sort_mode_now  = rcs_pkg::MODE_NAME_SURNAME;
  sorted_out_t                sorted_due_q[$];

  logic        idle_on      = 1'b1;
  int unsigned hold_request = 0;
  logic [7:0]  modes_used   = '0;
  int unsigned records_sent    = 0;
  int unsigned sets_closed     = 0;
  int unsigned results_checked = 0;
  int unsigned bad_results     = 0;
  int unsigned cycle_count     = 0;

  record_insertion_sorter #(
    .CAPACITY  (CAPACITY),
    .NAME_CHARS(NAME_CHARS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .first_name_i    (first_name),
    .surname_i       (surname),
    .birth_day_i     (birth_day),
    .birth_month_i   (birth_month),
    .birth_year_i    (birth_year),
    .record_number_i (record_number),
    .course_code_i   (course_code),
    .last_record_i   (last_record),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_first_name_o(out_first_name),
    .out_surname_o   (out_surname),
    .out_day_o       (out_day),
    .out_month_o     (out_month),
    .out_year_o      (out_year),
    .out_number_o    (out_number),
    .out_course_o    (out_course),
    .overflowed_o    (overflowed),
    .last_out_o      (last_out)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, sorted_due_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Key ordering
  // ---------------------------------------------------------------------

  // Append bytes of v (span bytes wide, first char on top) up to the first
  // zero byte, looking at no more than count bytes
  function automatic key_text_t append_text(key_text_t t, logic [63:0] v,
                                            int unsigned span, int unsigned count);
    logic       live;
    logic [7:0] c;
    live = 1'b1;
    for (int i = 0; i < count; i++) begin
      c = v[8*(span-i)-1 -: 8];
      if (live && c != 8'h00) begin
        t.bytes[127-8*t.n -: 8] = c;
        t.n = t.n + 5'd1;
      end else begin
        live = 1'b0;
      end
    end
    return t;
  endfunction

  function automatic key_text_t name_pair(logic [63:0] lead, logic [63:0] tail);
    return append_text(append_text('0, lead, 8, NAME_CHARS), tail, 8, NAME_CHARS);
  endfunction

  // Byte-wise unsigned compare; a proper prefix comes first
  function automatic logic text_precedes(key_text_t a, key_text_t b);
    logic       done;
    logic       less;
    logic [7:0] ca;
    logic [7:0] cb;
    done = 1'b0;
    less = 1'b0;
    for (int k = 0; k < 16; k++) begin
      ca = a.bytes[127-8*k -: 8];
      cb = b.bytes[127-8*k -: 8];
      if (!done && k < a.n && k < b.n && ca != cb) begin
        less = (ca < cb);
        done = 1'b1;
      end
    end
    if (!done) less = (a.n < b.n);
    return less;
  endfunction

  // Date as a decimal yyyymmdd-style number
  function automatic int unsigned date_rank(rcs_pkg::rec_t r);
    int unsigned y;
    int unsigned m;
    int unsigned d;
    y = r.year;
    m = r.month;
    d = r.day;
    return y * 10000 + m * 100 + d;
  endfunction

  function automatic logic key_precedes(rcs_pkg::rec_t fresh, rcs_pkg::rec_t held,
                                        logic [rcs_pkg::MODE_W-1:0] mode);
    logic less;
    case (mode)
      rcs_pkg::MODE_NAME_SURNAME:
        less = text_precedes(name_pair(fresh.first_name, fresh.surname),
                             name_pair(held.first_name, held.surname));
      rcs_pkg::MODE_SURNAME_NAME:
        less = text_precedes(name_pair(fresh.surname, fresh.first_name),
                             name_pair(held.surname, held.first_name));
      rcs_pkg::MODE_BIRTH_DATE:
        less = date_rank(fresh) < date_rank(held);
      rcs_pkg::MODE_NUMBER:
        less = fresh.number < held.number;
      rcs_pkg::MODE_COURSE:
        less = text_precedes(append_text('0, {40'h0, fresh.course}, 3, 3),
                             append_text('0, {40'h0, held.course}, 3, 3));
      default:
        less = 1'b0;
    endcase
    return less;
  endfunction

  // Stable insert of an accepted request; on the last one the whole roster
  // becomes due in order and the shadow empties
  task automatic sort_into_roster(rcs_pkg::rec_t fresh, logic last);
    int unsigned slot;
    sorted_out_t due;
    if (roster_q.size() >= CAPACITY) begin
      roster_dropped = 1'b1;
    end else begin
      slot = roster_q.size();
      while (slot > 0) begin
        if (!key_precedes(fresh, roster_q[slot-1], sort_mode_now)) break;
        slot--;
      end
      roster_q.push_back(fresh);
      for (int k = roster_q.size() - 1; k > slot; k--) roster_q[k] = roster_q[k-1];
      roster_q[slot] = fresh;
    end
    if (last) begin
      for (int k = 0; k < roster_q.size(); k++) begin
        due.rec        = roster_q[k];
        due.overflowed = roster_dropped;
        due.last       = (k == roster_q.size() - 1);
        sorted_due_q.push_back(due);
      end
      roster_q.delete();
      roster_dropped = 1'b0;
      sets_closed++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Record builders
  // ---------------------------------------------------------------------

  // Move a short literal up so its first character sits in the top byte
  function automatic logic [63:0] align_top(logic [63:0] v, int unsigned span);
    while (v != 0 && v[8*span-1 -: 8] == 8'h00) v = v << 8;
    return v;
  endfunction

  function automatic rcs_pkg::rec_t person(logic [63:0] fn, logic [63:0] sn, int unsigned y,
                                           int unsigned m, int unsigned d, int unsigned num,
                                           logic [63:0] crs);
    rcs_pkg::rec_t r;
    r.first_name = align_top(fn, 8);
    r.surname    = align_top(sn, 8);
    r.year       = 14'(y);
    r.month      = 4'(m);
    r.day        = 5'(d);
    r.number     = 31'(num);
    r.course     = 24'(align_top(crs, 3));
    return r;
  endfunction

  // Mostly short names over a narrow alphabet so ties and prefixes are
  // common; some raw words and some with junk past the terminator
  function automatic logic [63:0] random_name();
    logic [63:0] v;
    int unsigned len;
    int unsigned pick;
    v    = '0;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      v = {$urandom, $urandom};
    end else begin
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) v[63-8*i -: 8] = 8'(8'h41 + $urandom_range(0, 3));
      if (pick == 1 && len <= 6) v[55-8*len -: 8] = 8'($urandom_range(1, 255));
    end
    return v;
  endfunction

  function automatic logic [23:0] random_course();
    logic [23:0] c;
    int unsigned sel;
    c = '0;
    if ($urandom_range(0, 3) == 0) begin
      c = 24'($urandom);
    end else begin
      for (int i = 0; i < 3; i++) begin
        sel = $urandom_range(0, 2);
        c[23-8*i -: 8] = (sel == 0) ? 8'h00 : 8'(8'h40 + sel);
      end
    end
    return c;
  endfunction

  function automatic rcs_pkg::rec_t random_record();
    rcs_pkg::rec_t r;
    r.first_name = random_name();
    r.surname    = random_name();
    r.course     = random_course();
    if ($urandom_range(0, 1) == 0) begin
      // tight pools: many equal keys
      r.year   = 14'(1990 + $urandom_range(0, 2));
      r.month  = 4'($urandom_range(1, 2));
      r.day    = 5'($urandom_range(1, 3));
      r.number = 31'($urandom_range(0, 7));
    end else begin
      r.year   = 14'($urandom_range(0, 9999));
      r.month  = 4'($urandom_range(1, 12));
      r.day    = 5'($urandom_range(1, 31));
      r.number = 31'($urandom);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Offer one request and hold it until accepted
  task automatic send_record(rcs_pkg::rec_t r, logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    first_name    <= r.first_name;
    surname       <= r.surname;
    birth_day     <= r.day;
    birth_month   <= r.month;
    birth_year    <= r.year;
    record_number <= r.number;
    course_code   <= r.course;
    last_record   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    records_sent++;
    sort_into_roster(r, last);
  endtask

  // Stop offering, let all due results out and the last insert finish
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (sorted_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic [rcs_pkg::MODE_W-1:0] m);
    settle_idle();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we        <= 1'b0;
    sort_mode_now = m;
    modes_used[m] = 1'b1;
  endtask

  // Result side: random stall bursts, plus a long hold on request
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    bad_results++;
    if (bad_results <= MAX_REPORTS)
      $display("%0t: result %0d %s: expected %h, got %h",
               $realtime, results_checked, what, want, got);
  endtask

  task automatic compare_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) flag_mismatch(what, want, got);
  endtask

  always @(posedge clk) begin : result_check
    sorted_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_due_q.size() == 0) begin
        flag_mismatch("arrived with none pending (number)", '0, out_number);
      end else begin
        want = sorted_due_q.pop_front();
        compare_field("first name", want.rec.first_name, out_first_name);
        compare_field("surname",    want.rec.surname,    out_surname);
        compare_field("day",        want.rec.day,        out_day);
        compare_field("month",      want.rec.month,      out_month);
        compare_field("year",       want.rec.year,       out_year);
        compare_field("number",     want.rec.number,     out_number);
        compare_field("course",     want.rec.course,     out_course);
        compare_field("overflowed", want.overflowed,     overflowed);
        compare_field("last",       want.last,           last_out);
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes, every defined mode and an undefined one, equal keys, cut strings, mid-set mode change
  task automatic test_directed_keys();
    // name + surname: concatenation ties, prefix, zero byte mid-name, empty
    write_mode(rcs_pkg::MODE_NAME_SURNAME);
    send_record(person("BOB", "SMITH", 1980, 5, 17, 100, "CS"), 1'b0);
    send_record(person("AL", "ZED", 1981, 6, 18, 101, "CS"), 1'b0);
    send_record(person("BO", "BSMITH", 1982, 7, 19, 102, "EE"), 1'b0);
    send_record(person(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                       9999, 12, 31, 32'h7FFF_FFFF, 24'hFF_FFFF), 1'b0);
    send_record(person(64'h0, 64'h0, 0, 1, 1, 0, 24'h0), 1'b0);
    send_record(person(64'h414C_0058_5900_0000, "ZED", 1983, 8, 20, 103, "ME"), 1'b1);

    // surname + name
    write_mode(rcs_pkg::MODE_SURNAME_NAME);
    send_record(person("ANN", "LEE", 1990, 1, 1, 1, "AB"), 1'b0);
    send_record(person("LEE", "ANN", 1990, 1, 1, 2, "AB"), 1'b0);
    send_record(person("X", "LE", 1990, 1, 1, 3, "AB"), 1'b1);

    // birth date: extremes, month against day, equal dates
    write_mode(rcs_pkg::MODE_BIRTH_DATE);
    send_record(person("P", "Q", 9999, 12, 31, 4, "AB"), 1'b0);
    send_record(person("P", "Q", 0, 1, 1, 5, "AB"), 1'b0);
    send_record(person("P", "Q", 2000, 2, 1, 6, "AB"), 1'b0);
    send_record(person("R", "S", 2000, 1, 31, 7, "AB"), 1'b0);
    send_record(person("T", "U", 2000, 2, 1, 8, "AB"), 1'b1);

    // record number extremes and a tie
    write_mode(rcs_pkg::MODE_NUMBER);
    send_record(person("N", "N", 1, 1, 1, 32'h7FFF_FFFF, "AB"), 1'b0);
    send_record(person("N", "M", 1, 1, 1, 0, "AB"), 1'b0);
    send_record(person("N", "L", 1, 1, 1, 0, "AB"), 1'b1);

    // course: prefix, zero byte mid-code, equal after the cut
    write_mode(rcs_pkg::MODE_COURSE);
    send_record(person("C", "A", 1, 1, 1, 9, "ABC"), 1'b0);
    send_record(person("C", "B", 1, 1, 1, 9, "AB"), 1'b0);
    send_record(person("C", "C", 1, 1, 1, 9, 24'h41_005A), 1'b0);
    send_record(person("C", "D", 1, 1, 1, 9, 24'h41_0000), 1'b1);

    // undefined mode keeps arrival order
    write_mode(MODE_UNUSED_HI);
    send_record(person("ZZ", "ZZ", 9999, 12, 31, 99, "ZZZ"), 1'b0);
    send_record(person("AA", "AA", 0, 1, 1, 0, "AAA"), 1'b1);

    // mode changes mid-set; held records are not resorted
    write_mode(rcs_pkg::MODE_NUMBER);
    send_record(person("C", "C", 2001, 1, 1, 50, "X"), 1'b0);
    send_record(person("D", "D", 1999, 1, 1, 10, "X"), 1'b0);
    write_mode(rcs_pkg::MODE_BIRTH_DATE);
    send_record(person("E", "E", 2000, 6, 6, 5, "X"), 1'b0);
    send_record(person("F", "F", 1999, 1, 1, 70, "X"), 1'b1);
  endtask

  // Output held off for a long stretch while two sets queue up behind it
  task automatic test_output_backpressure();
    write_mode(rcs_pkg::MODE_NUMBER);
    hold_request = HOLD_CYCLES;
    for (int k = 0; k < 5; k++) send_record(random_record(), k == 4);
    for (int k = 0; k < 6; k++) send_record(random_record(), k == 5);
  endtask

  // Fill the store; the next request is dropped and the last one too
  task automatic test_capacity_overflow();
    write_mode(3'($urandom_range(rcs_pkg::MODE_NAME_SURNAME, rcs_pkg::MODE_COURSE)));
    for (int k = 0; k < CAPACITY + 2; k++) send_record(random_record(), k == CAPACITY + 1);
  endtask

  // Random sets over random modes, sometimes switching mode mid-set;
  // idling stops for the final stretch
  task automatic test_random_sets();
    int unsigned sent;
    int unsigned set_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS * 3 / 4) idle_on = 1'b0;
      if ($urandom_range(0, 5) == 0)
        write_mode(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)));
      else
        write_mode(3'($urandom_range(rcs_pkg::MODE_NAME_SURNAME, rcs_pkg::MODE_COURSE)));
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
      for (int k = 0; k < set_len; k++) begin
        if (set_len >= 4 && k == set_len / 2 && $urandom_range(0, 3) == 0)
          write_mode(3'($urandom_range(rcs_pkg::MODE_NAME_SURNAME, MODE_UNUSED_HI)));
        send_record(random_record(), k == set_len - 1);
      end
      sent += set_len;
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    first_name    <= '0;
    surname       <= '0;
    birth_day     <= '0;
    birth_month   <= '0;
    birth_year    <= '0;
    record_number <= '0;
    course_code   <= '0;
    last_record   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_keys();
    test_output_backpressure();
    test_capacity_overflow();
    test_random_sets();

    settle_idle();
    repeat (DRAIN_SLACK) @(posedge clk);

    $display("Covered %0d records in %0d sets, sort modes used %b, a full store with drops",
             records_sent, sets_closed, modes_used);
    $display("and a %0d-cycle output hold; %0d sorted records checked, %0d mismatches.",
             HOLD_CYCLES, results_checked, bad_results);
    if (bad_results == 0 && sorted_due_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
